[sv/ttb_pkg.sv]
// ----------------------------------------------------------------------------
// ttb_pkg : shared types and constants for the tangent basis block
// holds the fixed output format, the vertex phases of the front and the solver states of the back
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int OUT_W     = 32;

    typedef enum logic [1:0] {
        PH_V0 = 2'd0,
        PH_V1 = 2'd1,
        PH_V2 = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_SUM  = 3'd2,
        BK_DIV  = 3'd3,
        BK_SEND = 3'd4
    } t_bk_state;

endpackage

[sv/triangle_tangent_basis.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_basis : per-triangle tangent and bitangent from uv
// collects three vertices, solves the uv basis, sends it once per vertex
// ----------------------------------------------------------------------------
// the bit-serial divider shared by the six components sets the rate; a zero
//   uv determinant skips it, and the queue lets two triangles be collected
//   meanwhile
// reset: synchronous active-low i_rst_n clears phase, queue and solver state
module triangle_tangent_basis
    import ttb_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    parameter int UV_WIDTH       = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up, zero padded
    input  logic [((3*POSITION_WIDTH+2*UV_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tangent_x/y/z, bitangent_x/y/z from bit 0 up
    output logic [6*OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    localparam int PW = POSITION_WIDTH;
    localparam int UW = UV_WIDTH;
    localparam int QW = 3*2*(PW+1)+4*(UW+1);

    logic          q_full, q_push, q_pop, q_valid;
    logic [QW-1:0] q_in, q_out;

    // front: vertex collection and deltas
    ttb_front #(.PW(PW), .UW(UW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_px    (s_axis_tdata[0 +: PW]),
        .i_py    (s_axis_tdata[PW +: PW]),
        .i_pz    (s_axis_tdata[2*PW +: PW]),
        .i_u     (s_axis_tdata[3*PW +: UW]),
        .i_v     (s_axis_tdata[3*PW+UW +: UW]),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_data  (q_in)
    );

    // request queue decoupling collection from solving
    ttb_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // back: products, determinant, division, three copies out
    ttb_back #(.PW(PW), .UW(UW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_out),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_vec   (m_axis_tdata),
        .o_degen (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );
endmodule

[sv/ttb_queue.sv]
// ----------------------------------------------------------------------------
// ttb_queue : two-entry queue between front and back
// carries the deltas of one triangle per entry
// ----------------------------------------------------------------------------
module ttb_queue
    import ttb_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

[sv/ttb_front.sv]
// ----------------------------------------------------------------------------
// ttb_front : vertex collector
// holds the first two vertices and forms the deltas on the third
// ----------------------------------------------------------------------------
module ttb_front
    import ttb_pkg::*;
#(
    parameter int PW = 24,
    parameter int UW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [PW-1:0] i_px, i_py, i_pz,
    input  logic signed [UW-1:0] i_u, i_v,
    input  logic                i_q_full,
    output logic                o_push,
    output logic [3*2*(PW+1)+4*(UW+1)-1:0] o_data
);
    logic signed [PW-1:0] r_p0 [3];
    logic signed [PW-1:0] r_p1 [3];
    logic signed [UW-1:0] r_uv0 [2];
    logic signed [UW-1:0] r_uv1 [2];
    t_phase               r_ph;
    logic                 acc;
    logic signed [PW:0]   d1x, d1y, d1z, d2x, d2y, d2z;
    logic signed [UW:0]   du1, dv1, du2, dv2;

    assign o_ready = !(r_ph == PH_V2 && i_q_full);
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && (r_ph == PH_V2);

    assign d1x = {r_p1[0][PW-1], r_p1[0]} - {r_p0[0][PW-1], r_p0[0]};
    assign d1y = {r_p1[1][PW-1], r_p1[1]} - {r_p0[1][PW-1], r_p0[1]};
    assign d1z = {r_p1[2][PW-1], r_p1[2]} - {r_p0[2][PW-1], r_p0[2]};
    assign d2x = {i_px[PW-1], i_px} - {r_p0[0][PW-1], r_p0[0]};
    assign d2y = {i_py[PW-1], i_py} - {r_p0[1][PW-1], r_p0[1]};
    assign d2z = {i_pz[PW-1], i_pz} - {r_p0[2][PW-1], r_p0[2]};
    assign du1 = {r_uv1[0][UW-1], r_uv1[0]} - {r_uv0[0][UW-1], r_uv0[0]};
    assign dv1 = {r_uv1[1][UW-1], r_uv1[1]} - {r_uv0[1][UW-1], r_uv0[1]};
    assign du2 = {i_u[UW-1], i_u} - {r_uv0[0][UW-1], r_uv0[0]};
    assign dv2 = {i_v[UW-1], i_v} - {r_uv0[1][UW-1], r_uv0[1]};

    assign o_data = {dv2, du2, dv1, du1, d2z, d2y, d2x, d1z, d1y, d1x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_V0;
        end else if (acc) begin
            case (r_ph)
                PH_V0:   r_ph <= PH_V1;
                PH_V1:   r_ph <= PH_V2;
                default: r_ph <= PH_V0;
            endcase
        end
        if (acc && r_ph == PH_V0) begin
            r_p0[0] <= i_px; r_p0[1] <= i_py; r_p0[2] <= i_pz;
            r_uv0[0] <= i_u; r_uv0[1] <= i_v;
        end
        if (acc && r_ph == PH_V1) begin
            r_p1[0] <= i_px; r_p1[1] <= i_py; r_p1[2] <= i_pz;
            r_uv1[0] <= i_u; r_uv1[1] <= i_v;
        end
    end
endmodule

[sv/ttb_back.sv]
// ----------------------------------------------------------------------------
// ttb_back : basis solver
// forms the numerators and the determinant, divides bit-serially, sends three copies
// ----------------------------------------------------------------------------
module ttb_back
    import ttb_pkg::*;
#(
    parameter int PW = 24,
    parameter int UW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [3*2*(PW+1)+4*(UW+1)-1:0] i_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [6*OUT_W-1:0]      o_vec,
    output logic                    o_degen,
    output logic                    o_last
);
    localparam int DW = PW + 1;
    localparam int EW = UW + 1;
    localparam int PRW = DW + EW;          // product width
    localparam int NW  = PRW + 1;          // numerator width
    localparam int MW  = 2 * EW + 1;       // determinant width
    localparam int QB  = 32;               // quotient bits: 19 integer + 13 fraction
    localparam int DVW = NW + FRAC_BITS + 1; // shifted dividend width
    localparam int CW  = $clog2(QB + 1);

    t_bk_state r_st, n_st;

    logic signed [DW-1:0] d1 [3];
    logic signed [DW-1:0] d2 [3];
    logic signed [EW-1:0] du1, dv1, du2, dv2;

    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic signed [EW-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PRW-1:0] r_pa [6];   // d1*dv2, d2*du1
    logic signed [PRW-1:0] r_pb [6];   // d2*dv1, d1*du2
    logic signed [2*EW-1:0] r_ma, r_mb;
    logic signed [NW-1:0]  r_num [6];
    logic signed [MW-1:0]  r_det;
    logic [2:0]            r_idx;
    logic [CW-1:0]         r_bit;
    logic [DVW-1:0]        r_rem;
    logic [QB-1:0]         r_q;
    logic [DVW-1:0]        r_dvd;
    logic                  r_neg;
    logic                  r_ovf;
    logic [OUT_W-1:0]      r_res [6];
    logic [1:0]            r_copy;
    logic                  r_degen;

    logic [NW-1:0]   un;
    logic [MW-1:0]   ud;
    logic [DVW-1:0]  rem_sh, trial;
    logic [QB:0]     mag;
    logic [OUT_W-1:0] sres;
    logic            done_div;
    logic            ovf;

    genvar g;
    for (g = 0; g < 3; g++) begin : g_unp
        assign d1[g] = i_data[g*DW +: DW];
        assign d2[g] = i_data[(3+g)*DW +: DW];
    end
    assign du1 = i_data[6*DW +: EW];
    assign dv1 = i_data[6*DW+EW +: EW];
    assign du2 = i_data[6*DW+2*EW +: EW];
    assign dv2 = i_data[6*DW+3*EW +: EW];

    // restoring division on magnitudes, one quotient bit a cycle
    assign un     = r_num[r_idx][NW-1] ? NW'(-r_num[r_idx]) : NW'(r_num[r_idx]);
    assign ud     = r_det[MW-1] ? MW'(-r_det) : MW'(r_det);
    assign rem_sh = {r_rem[DVW-2:0], r_dvd[DVW-1]};
    assign trial  = rem_sh - DVW'(ud);
    assign done_div = (r_bit == CW'(QB));
    // integer part of 2^19 or more cannot fit the output range
    assign ovf    = DVW'(un >> (QB - FRAC_BITS - 1)) >= DVW'(ud);
    // r_q holds value*2^13, round half up then saturate
    assign mag = ({1'b0, r_q} + (QB+1)'(1)) >> 1;
    always_comb begin
        if (r_ovf) begin
            sres = r_neg ? 32'h80000000 : 32'h7fffffff;
        end else if (r_neg) begin
            if (mag >= (QB+1)'(33'h80000000)) sres = 32'h80000000;
            else sres = OUT_W'(-mag);
        end else begin
            if (mag > (QB+1)'(33'h7fffffff)) sres = 32'h7fffffff;
            else sres = OUT_W'(mag);
        end
    end

    assign o_pop = (r_st == BK_IDLE) && i_valid;

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_valid) n_st = BK_MUL;
            BK_MUL:  n_st = BK_SUM;
            BK_SUM:  n_st = BK_DIV;
            BK_DIV:  if ((done_div && r_idx == 3'd5) || r_det == '0) n_st = BK_SEND;
            BK_SEND: if (i_ready && r_copy == 2'd2) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        o_valid = (r_st == BK_SEND);
        o_last  = (r_copy == 2'd2);
        o_degen = r_degen;
        for (int k = 0; k < 6; k++) o_vec[k*OUT_W +: OUT_W] = r_res[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
        end else begin
            r_st <= n_st;
        end
        case (r_st)
            BK_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_d1[k] <= d1[k];
                    r_d2[k] <= d2[k];
                end
                r_du1 <= du1; r_dv1 <= dv1; r_du2 <= du2; r_dv2 <= dv2;
                r_copy <= 2'd0;
            end
            BK_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_pa[k]   <= PRW'(r_d1[k] * r_dv2);
                    r_pb[k]   <= PRW'(r_d2[k] * r_dv1);
                    r_pa[3+k] <= PRW'(r_d2[k] * r_du1);
                    r_pb[3+k] <= PRW'(r_d1[k] * r_du2);
                end
                r_ma <= (2*EW)'(r_du1 * r_dv2);
                r_mb <= (2*EW)'(r_dv1 * r_du2);
            end
            BK_SUM: begin
                for (int k = 0; k < 6; k++)
                    r_num[k] <= NW'(r_pa[k]) - NW'(r_pb[k]);
                r_det   <= MW'(r_ma) - MW'(r_mb);
                r_idx   <= 3'd0;
                r_bit   <= CW'(QB + 1);
            end
            BK_DIV: begin
                r_degen <= (r_det == '0);
                if (r_det == '0) begin
                    for (int k = 0; k < 6; k++) r_res[k] <= '0;
                end else if (r_bit == CW'(QB + 1)) begin
                    // load: the dividend bits above the quotient width seed the remainder
                    r_dvd <= {un[QB-FRAC_BITS-2:0], {(FRAC_BITS+1){1'b0}},
                              {(DVW-QB){1'b0}}};
                    r_rem <= DVW'(un >> (QB - FRAC_BITS - 1));
                    r_ovf <= ovf;
                    r_q   <= '0;
                    r_neg <= r_num[r_idx][NW-1] ^ r_det[MW-1];
                    r_bit <= '0;
                end else if (!done_div) begin
                    // one quotient bit
                    r_dvd <= r_dvd << 1;
                    if (trial[DVW-1] == 1'b0) begin
                        r_rem <= trial;
                        r_q   <= {r_q[QB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q   <= {r_q[QB-2:0], 1'b0};
                    end
                    r_bit <= r_bit + CW'(1);
                end else begin
                    r_res[r_idx] <= sres;
                    r_idx <= r_idx + 3'd1;
                    r_bit <= CW'(QB + 1);
                end
            end
            BK_SEND: if (i_ready) r_copy <= r_copy + 2'd1;
            default: ;
        endcase
    end
endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : testbench for triangle_tangent_basis
// streams vertices, predicts each triangle's tangent and bitangent in fixed
// point and checks every result copy, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
    import ttb_pkg::*;

    localparam int PW  = 24;
    localparam int UVW = 16;
    localparam int IN_W = ((3*PW+2*UVW+7)/8)*8;

    typedef struct {
        logic signed [OUT_W-1:0] tan [3];
        logic signed [OUT_W-1:0] bitan [3];
        logic degenerate;
        logic last;
    } t_basis;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [6*OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    // expected results, oldest first
    t_basis basis_q [$];
    int     fail_count = 0;
    bit     gaps_on = 1'b1;

    // vertices held by the predictor for the triangle in progress
    longint held_p [2][3];
    longint held_uv [2][2];
    int     vert_idx = 0;

    triangle_tangent_basis DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // rounded, saturated num * 2^12 / den, den not zero
    function automatic logic signed [31:0] fix_div(longint num, longint den);
        bit          neg;
        bit [63:0]   un, ud, q0, r0, mag;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q0 = un / ud;
        r0 = un % ud;
        if (q0 >= (64'd1 << (31 - FRAC_BITS)))
            mag = 64'd1 << 32;
        else
            mag = ((q0 << (FRAC_BITS+1)) + (r0 << (FRAC_BITS+1)) / ud + 1) >> 1;
        if (neg)
            return mag >= (64'd1 << 31) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        return mag > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : mag[31:0];
    endfunction

    // accepted vertex: store it, or solve the triangle on the third one
    task automatic predict_vertex(longint p[3], longint uv[2]);
        longint dp1, dp2, du1, dv1, du2, dv2, det;
        t_basis r;
        if (vert_idx < 2) begin
            held_p[vert_idx] = p;
            held_uv[vert_idx] = uv;
            vert_idx++;
            return;
        end
        vert_idx = 0;
        du1 = held_uv[1][0] - held_uv[0][0];
        dv1 = held_uv[1][1] - held_uv[0][1];
        du2 = uv[0] - held_uv[0][0];
        dv2 = uv[1] - held_uv[0][1];
        det = du1*dv2 - dv1*du2;
        for (int i = 0; i < 3; i++) begin
            dp1 = held_p[1][i] - held_p[0][i];
            dp2 = p[i] - held_p[0][i];
            r.tan[i]   = det == 0 ? '0 : fix_div(dp1*dv2 - dp2*dv1, det);
            r.bitan[i] = det == 0 ? '0 : fix_div(dp2*du1 - dp1*du2, det);
        end
        r.degenerate = det == 0;
        for (int k = 0; k < 3; k++) begin
            r.last = k == 2;
            basis_q.insert(basis_q.size(), r);
        end
    endtask

    // one vertex request, driven at the falling edge
    task automatic send_vertex(longint px, longint py, longint pz, longint u, longint v);
        int     gap;
        longint p[3];
        longint uv[2];
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v[UVW-1:0], u[UVW-1:0], pz[PW-1:0], py[PW-1:0], px[PW-1:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p[0] = $signed(px[PW-1:0]);
        p[1] = $signed(py[PW-1:0]);
        p[2] = $signed(pz[PW-1:0]);
        uv[0] = $signed(u[UVW-1:0]);
        uv[1] = $signed(v[UVW-1:0]);
        predict_vertex(p, uv);
        @(negedge i_clk);
    endtask

    function automatic longint rnd_pos();
        return $signed(PW'($urandom));
    endfunction

    function automatic longint rnd_uv();
        return $signed(UVW'($urandom));
    endfunction

    // receiver stalls
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = gaps_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_basis e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (basis_q.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                e = basis_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_axis_tdata[i*OUT_W +: OUT_W] !== e.tan[i]) begin
                        $error("tangent[%0d] expected %0d got %0d", i, e.tan[i],
                               $signed(m_axis_tdata[i*OUT_W +: OUT_W]));
                        fail_count++;
                    end
                    if (m_axis_tdata[(i+3)*OUT_W +: OUT_W] !== e.bitan[i]) begin
                        $error("bitangent[%0d] expected %0d got %0d", i, e.bitan[i],
                               $signed(m_axis_tdata[(i+3)*OUT_W +: OUT_W]));
                        fail_count++;
                    end
                end
                if (m_axis_tuser !== e.degenerate) begin
                    $error("degenerate expected %0d got %0d", e.degenerate, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last expected %0d got %0d", e.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        longint pmax, pmin, umax, umin;
        pmax = 8388607; pmin = -8388608; umax = 32767; umin = -32768;
        // unit square uv, simple positions
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(4096, 0, 0, 4096, 0);
        send_vertex(0, 4096, 0, 0, 4096);
        // degenerate: all uv equal
        send_vertex(100, 200, 300, 77, 77);
        send_vertex(-5, 6, 7, 77, 77);
        send_vertex(9, -9, 9, 77, 77);
        // position extremes, uv extremes
        send_vertex(pmin, pmax, pmin, umin, umin);
        send_vertex(pmax, pmin, pmax, umax, umin);
        send_vertex(pmin, pmin, pmax, umin, umax);
        // tiny det with huge edges: saturation both ways
        send_vertex(pmin, pmax, 0, 0, 0);
        send_vertex(pmax, pmin, 0, 1, 0);
        send_vertex(pmin, pmax, pmax, 0, 1);
        // colinear uv, non-trivial degenerate
        send_vertex(1, 2, 3, 10, 20);
        send_vertex(4, 5, 6, 20, 40);
        send_vertex(7, 8, 9, 30, 60);
        // all ones / all zeros bit patterns
        send_vertex(-1, -1, -1, -1, -1);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(-1, 0, -1, 0, -1);
    endtask

    task automatic test_random(int tris);
        for (int t = 0; t < tris; t++) begin
            gaps_on = (t % 40) >= 8;   // a stretch without idling now and then
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 3))
                    0: send_vertex(rnd_pos(), rnd_pos(), rnd_pos(), rnd_uv(), rnd_uv());
                    // small uv spread gives large quotients
                    1: send_vertex(rnd_pos(), rnd_pos(), rnd_pos(),
                                   $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
                    2: send_vertex($urandom_range(0, 65535) - 32768,
                                   $urandom_range(0, 65535) - 32768,
                                   $urandom_range(0, 65535) - 32768,
                                   $urandom_range(0, 8191), $urandom_range(0, 8191));
                    default: send_vertex(rnd_pos(), rnd_pos(), rnd_pos(), 5, $urandom_range(0, 1));
                endcase
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        int guard;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(162);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (basis_q.size() != 0 && guard < 500000) begin
            @(posedge i_clk);
            guard++;
        end
        // allow for any stray result after the last one
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && basis_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
